// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define AST_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define AST_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/lewh_pkg.sv =====
// Shared types, constants and echo tables for the line editor.
`timescale 1ns / 1ps
`default_nettype none
package lewh_pkg;

  localparam int LINE_LEN_DEF   = 64;
  localparam int HIST_DEPTH_DEF = 32;
  localparam logic [7:0] VIEW_WIDTH_RST = 8'd72;

  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [3:0] CMD_CHAR  = 4'd0;
  localparam logic [3:0] CMD_INS   = 4'd1;
  localparam logic [3:0] CMD_HOME  = 4'd2;
  localparam logic [3:0] CMD_END   = 4'd3;
  localparam logic [3:0] CMD_UP    = 4'd4;
  localparam logic [3:0] CMD_DOWN  = 4'd5;
  localparam logic [3:0] CMD_LEFT  = 4'd6;
  localparam logic [3:0] CMD_RIGHT = 4'd7;
  localparam logic [3:0] CMD_BKSP  = 4'd8;
  localparam logic [3:0] CMD_DEL   = 4'd9;
  localparam logic [3:0] CMD_ENTER = 4'd10;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_ECHO   = 2'd1,
    KIND_LINE   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    EM_STATUS,
    EM_INS,
    EM_OVR,
    EM_BS,
    EM_LINE
  } emit_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DISP,
    ST_SH_RD,
    ST_SH_WR,
    ST_CH_WR,
    ST_DL_RD,
    ST_DL_WR,
    ST_WALK_RD,
    ST_WALK_CK,
    ST_WB,
    ST_FIN_RD,
    ST_FIN_LD,
    ST_EM_RD,
    ST_EM_SET,
    ST_EM_WAIT
  } state_t;

  // ESC [ 1 @ ch
  function automatic logic [7:0] echo_ins(input logic [3:0] idx, input logic [7:0] ch);
    logic [7:0] b;
    case (idx)
      4'd0:    b = CH_ESC;
      4'd1:    b = CH_LBRK;
      4'd2:    b = CH_ONE;
      4'd3:    b = CH_AT;
      default: b = ch;
    endcase
    return b;
  endfunction

  // ESC [ 1 D space ESC [ 1 D
  function automatic logic [7:0] echo_bs(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0, 4'd5: b = CH_ESC;
      4'd1, 4'd6: b = CH_LBRK;
      4'd2, 4'd7: b = CH_ONE;
      4'd4:       b = CH_SPACE;
      default:    b = CH_D;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// ===== src/line_editor_with_history_top.sv =====
// Line editor with history ring: sequencer, line memory and slot table.
//
//  channel  | dir | handshake               | payload
//  s_axis   | in  | s_axis_tvalid/tready    | tdata key_byte, tuser cmd
//  m_axis   | out | m_axis_tvalid/tready    | tdata status + byte, tuser kind, tlast
//  cfg      | in  | cfg_valid/cfg_ready     | cfg_data view_width
//
//  One key event at a time; s_axis_tready is low until its last beat is taken.
//  Line shifts move one byte per ST_SH_RD, ST_SH_WR pair through the line memory.
//  History walks probe one slot per ST_WALK_RD, ST_WALK_CK pair on the table read port.
//  Each output beat passes ST_EM_RD, ST_EM_SET, then ST_EM_WAIT until it is taken;
//  overhead is ST_LOAD, ST_DISP, ST_WB for all but enter, ST_FIN_RD/LD for up, down.
//  Reset is synchronous; the slot table has per-slot valid bits, no clear pass.
`timescale 1ns / 1ps
`default_nettype none
module line_editor_with_history_top #(
  parameter int LINE_LEN   = lewh_pkg::LINE_LEN_DEF,
  parameter int HIST_DEPTH = lewh_pkg::HIST_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] key_byte
  input  logic [3:0]  s_axis_tuser,   // [3:0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] data_byte, [14:8] line_length, [21:15] cursor_pos, [28:22] view_offset,
  // [29] insert_on, [34:30] slot_now, [39:35] zero
  output logic [39:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data        // [7:0] view_width
);
  import lewh_pkg::*;

  localparam int LW = $clog2(LINE_LEN + 1);
  localparam int PW = $clog2(LINE_LEN);
  localparam int SW = $clog2(HIST_DEPTH);
  localparam int KW = $clog2(HIST_DEPTH + 1);
  localparam int MW = 3 * LW;
  localparam int BD = HIST_DEPTH << PW;
  localparam logic [LW-1:0] LEN_MAX   = LW'(LINE_LEN);
  localparam logic [SW-1:0] SLOT_LAST = SW'(HIST_DEPTH - 1);
  localparam logic [KW-1:0] K_LAST    = KW'(HIST_DEPTH);

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    return (s == SLOT_LAST) ? '0 : s + SW'(1);
  endfunction

  function automatic logic [SW-1:0] slot_dec(input logic [SW-1:0] s);
    return (s == '0) ? SLOT_LAST : s - SW'(1);
  endfunction

  state_t state, state_next;

  logic [7:0]    view_width;
  logic [SW-1:0] cur_slot;
  logic          insert_mode;
  logic [3:0]    cmd_r;
  logic [7:0]    key_r;
  logic [SW-1:0] ws;
  logic [LW-1:0] w_len, w_cur, w_view;
  logic [LW-1:0] idx;
  logic [SW-1:0] probe, probe_prev;
  logic [KW-1:0] k;
  emit_t         emode;
  logic [LW-1:0] e_idx, e_cnt;
  logic [LW-1:0] st_len, st_cur, st_view;
  logic [SW-1:0] st_slot;
  kind_t         o_kind;
  logic [7:0]    o_byte;
  logic          o_last;

  // slot table
  logic [MW-1:0]         meta_mem [HIST_DEPTH];
  logic [HIST_DEPTH-1:0] meta_valid;
  logic [MW-1:0]         meta_q;
  logic                  meta_vq;
  logic [SW-1:0]         meta_raddr;
  logic                  meta_we;
  logic [LW-1:0]         q_len, q_cur, q_view;

  // line memory, slot-major
  logic [7:0]       byte_mem [BD];
  logic [7:0]       byte_q;
  logic [SW+PW-1:0] byte_raddr, byte_waddr;
  logic [7:0]       byte_wdata;
  logic             byte_we;

  logic [8:0]    view_sum, view_diff;
  logic [LW-1:0] view_new;
  logic          walk_hit;
  logic          is_walk;
  logic [SW+4:0] slot_ext;

  assign q_len  = meta_vq ? meta_q[3*LW-1:2*LW] : '0;
  assign q_cur  = meta_vq ? meta_q[2*LW-1:LW]   : '0;
  assign q_view = meta_vq ? meta_q[LW-1:0]      : '0;

  assign view_sum  = 9'(w_view) + 9'(view_width);
  assign view_diff = 9'(w_cur) - 9'(view_width);
  always_comb begin
    if (w_cur < w_view) begin
      view_new = w_cur;
    end else if (9'(w_cur) > view_sum) begin
      view_new = view_diff[LW-1:0];
    end else begin
      view_new = w_view;
    end
  end

  assign walk_hit = (q_len != '0);
  assign is_walk  = (cmd_r == CMD_UP) || (cmd_r == CMD_DOWN);

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = (state == ST_EM_WAIT);
  assign m_axis_tuser  = o_kind;
  assign m_axis_tlast  = o_last;
  assign slot_ext      = (SW + 5)'(st_slot);
  assign m_axis_tdata  = {5'd0, slot_ext[4:0], insert_mode, 7'(st_view), 7'(st_cur),
                          7'(st_len), o_byte};

  // next state and memory port control
  always_comb begin
    state_next = state;
    meta_raddr = cur_slot;
    meta_we    = 1'b0;
    byte_raddr = {ws, e_idx[PW-1:0]};
    byte_waddr = {ws, idx[PW-1:0]};
    byte_wdata = byte_q;
    byte_we    = 1'b0;
    case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) state_next = ST_LOAD;
      end
      ST_LOAD: state_next = ST_DISP;
      ST_DISP: begin
        case (cmd_r)
          CMD_ENTER: state_next = ST_EM_RD;
          CMD_CHAR: begin
            if (key_r == 8'd0 || w_len >= LEN_MAX) begin
              state_next = ST_WB;
            end else if (insert_mode || w_cur >= w_len) begin
              state_next = ST_SH_RD;
            end else begin
              state_next = ST_CH_WR;
            end
          end
          CMD_UP, CMD_DOWN: state_next = ST_WALK_RD;
          CMD_BKSP: state_next = (w_len != '0 && w_cur != '0) ? ST_DL_RD : ST_WB;
          CMD_DEL:  state_next = (w_len != '0 && w_cur < w_len) ? ST_DL_RD : ST_WB;
          default:  state_next = ST_WB;
        endcase
      end
      ST_SH_RD: begin
        byte_raddr = {ws, PW'(idx - LW'(1))};
        state_next = (idx > w_cur) ? ST_SH_WR : ST_CH_WR;
      end
      ST_SH_WR: begin
        byte_we    = 1'b1;
        state_next = ST_SH_RD;
      end
      ST_CH_WR: begin
        byte_we    = 1'b1;
        byte_waddr = {ws, w_cur[PW-1:0]};
        byte_wdata = key_r;
        state_next = ST_WB;
      end
      ST_DL_RD: begin
        byte_raddr = {ws, PW'(idx + LW'(1))};
        state_next = (idx + LW'(1) < w_len) ? ST_DL_WR : ST_WB;
      end
      ST_DL_WR: begin
        byte_we    = 1'b1;
        state_next = ST_DL_RD;
      end
      ST_WALK_RD: begin
        meta_raddr = probe;
        state_next = ST_WALK_CK;
      end
      ST_WALK_CK: begin
        state_next = (walk_hit || k == K_LAST) ? ST_WB : ST_WALK_RD;
      end
      ST_WB: begin
        meta_we    = 1'b1;
        state_next = is_walk ? ST_FIN_RD : ST_EM_RD;
      end
      ST_FIN_RD: state_next = ST_FIN_LD;
      ST_FIN_LD: state_next = ST_EM_RD;
      ST_EM_RD:  state_next = ST_EM_SET;
      ST_EM_SET: state_next = ST_EM_WAIT;
      ST_EM_WAIT: begin
        if (m_axis_tready) state_next = o_last ? ST_IDLE : ST_EM_RD;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    meta_q  <= meta_mem[meta_raddr];
    meta_vq <= meta_valid[meta_raddr];
    if (meta_we) meta_mem[ws] <= {w_len, w_cur, view_new};
  end

  always_ff @(posedge clk) begin
    byte_q <= byte_mem[byte_raddr];
    if (byte_we) byte_mem[byte_waddr] <= byte_wdata;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      view_width  <= VIEW_WIDTH_RST;
      cur_slot    <= '0;
      insert_mode <= 1'b1;
      meta_valid  <= '0;
    end else begin
      if (cfg_valid) view_width <= cfg_data;
      if (state == ST_DISP && cmd_r == CMD_INS) insert_mode <= ~insert_mode;
      if (state == ST_WALK_CK && walk_hit) begin
        cur_slot <= (k == KW'(1)) ? probe : probe_prev;
      end
      if (meta_we) meta_valid[ws] <= 1'b1;
      // enter commits: move on and empty the new slot
      if (state == ST_EM_WAIT && m_axis_tready && o_last && emode == EM_LINE) begin
        cur_slot                     <= slot_inc(ws);
        meta_valid[slot_inc(ws)]     <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cmd_r <= s_axis_tuser;
        key_r <= s_axis_tdata;
        ws    <= cur_slot;
        e_idx <= '0;
      end
      ST_LOAD: begin
        w_len  <= q_len;
        w_cur  <= q_cur;
        w_view <= q_view;
        emode  <= EM_STATUS;
        e_cnt  <= LW'(1);
      end
      ST_DISP: begin
        case (cmd_r)
          CMD_ENTER: begin
            if (w_len != '0) begin
              emode   <= EM_LINE;
              e_cnt   <= w_len;
              st_len  <= '0;
              st_cur  <= '0;
              st_view <= '0;
              st_slot <= slot_inc(ws);
            end else begin
              st_len  <= w_len;
              st_cur  <= w_cur;
              st_view <= w_view;
              st_slot <= ws;
            end
          end
          CMD_CHAR: begin
            if (key_r == 8'd0 || w_len >= LEN_MAX) begin
              emode <= EM_STATUS;
            end else if (insert_mode || w_cur >= w_len) begin
              emode <= EM_INS;
              e_cnt <= LW'(5);
              idx   <= w_len;
            end else begin
              emode <= EM_OVR;
            end
          end
          CMD_HOME: w_cur <= '0;
          CMD_END:  w_cur <= w_len;
          CMD_LEFT: begin
            if (w_cur != '0) w_cur <= w_cur - LW'(1);
          end
          CMD_RIGHT: begin
            if (w_cur < w_len) w_cur <= w_cur + LW'(1);
          end
          CMD_UP: begin
            probe      <= slot_dec(ws);
            probe_prev <= ws;
            k          <= KW'(1);
          end
          CMD_DOWN: begin
            probe      <= slot_inc(ws);
            probe_prev <= ws;
            k          <= KW'(1);
          end
          CMD_BKSP: begin
            if (w_len != '0 && w_cur != '0) begin
              emode <= EM_BS;
              e_cnt <= LW'(9);
              idx   <= w_cur - LW'(1);
            end
          end
          CMD_DEL: idx <= w_cur;
          default: ;
        endcase
      end
      ST_SH_WR: idx <= idx - LW'(1);
      ST_CH_WR: begin
        if (emode == EM_INS) w_len <= w_len + LW'(1);
        w_cur <= w_cur + LW'(1);
      end
      ST_DL_RD: begin
        if (!(idx + LW'(1) < w_len)) begin
          w_len <= w_len - LW'(1);
          if (cmd_r == CMD_BKSP) w_cur <= w_cur - LW'(1);
        end
      end
      ST_DL_WR: idx <= idx + LW'(1);
      ST_WALK_CK: begin
        probe_prev <= probe;
        probe      <= (cmd_r == CMD_UP) ? slot_dec(probe) : slot_inc(probe);
        k          <= k + KW'(1);
      end
      ST_WB: begin
        st_len  <= w_len;
        st_cur  <= w_cur;
        st_view <= view_new;
        st_slot <= ws;
      end
      ST_FIN_LD: begin
        st_len  <= q_len;
        st_cur  <= q_cur;
        st_view <= q_view;
        st_slot <= cur_slot;
      end
      ST_EM_SET: begin
        o_last <= (e_idx + LW'(1) == e_cnt);
        case (emode)
          EM_INS: begin
            o_kind <= KIND_ECHO;
            o_byte <= echo_ins(e_idx[3:0], key_r);
          end
          EM_OVR: begin
            o_kind <= KIND_ECHO;
            o_byte <= key_r;
          end
          EM_BS: begin
            o_kind <= KIND_ECHO;
            o_byte <= echo_bs(e_idx[3:0]);
          end
          EM_LINE: begin
            o_kind <= KIND_LINE;
            o_byte <= byte_q;
          end
          default: begin
            o_kind <= KIND_STATUS;
            o_byte <= 8'd0;
          end
        endcase
      end
      ST_EM_WAIT: begin
        if (m_axis_tready) e_idx <= e_idx + LW'(1);
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== src/lewh_checker.sv =====
// Port-level checker for the line editor, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module lewh_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);
  import lewh_pkg::*;

  // one event at a time: no input taken while a beat is offered
  `AST_IMP(a_one_event, clk, rst, m_axis_tvalid, !s_axis_tready)
  // an accepted event holds off the input side next cycle
  `AST_NXT(a_busy_after_accept, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // status beats carry no byte and close the event
  `AST_IMP(a_status_beat, clk, rst, m_axis_tvalid && m_axis_tuser == KIND_STATUS,
           m_axis_tlast && m_axis_tdata[7:0] == 8'd0)
  // a taken final beat frees the input side
  `AST_NXT(a_ready_after_last, clk, rst, m_axis_tvalid && m_axis_tready && m_axis_tlast,
           s_axis_tready)
  `AST_IMP(a_kind_legal, clk, rst, m_axis_tvalid,
           m_axis_tuser == KIND_STATUS || m_axis_tuser == KIND_ECHO ||
           m_axis_tuser == KIND_LINE)

endmodule

bind line_editor_with_history_top lewh_checker u_lewh_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

// ===== sim/line_editor_with_history_top_test.sv =====
// Self-checking testbench for the line editor with history ring.
`timescale 1ns / 1ps
module line_editor_with_history_top_test;
  import lewh_pkg::*;

  localparam int LINES = HIST_DEPTH_DEF;
  localparam int COLS = LINE_LEN_DEF;
  localparam logic [3:0] CMD_BAD_LO = 4'd11;
  localparam logic [3:0] CMD_BAD_HI = 4'd15;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
    logic [6:0] len;
    logic [6:0] cpos;
    logic [6:0] view;
    logic       ins;
    logic [4:0] slot;
  } beat_t;

  typedef struct {
    logic [3:0] cmd;
    logic [7:0] key;
    bit         typed;
    beat_t      want;
  } key_row_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 0;
  logic [3:0]  s_axis_tuser = 0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = 0;

  line_editor_with_history_top dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // editor state mirror
  logic [7:0] line_mem [LINES][COLS];
  int slot_len [LINES];
  int slot_cur [LINES];
  int slot_view [LINES];
  int active_slot = 0;
  bit insert_mode = 1;
  int view_width = VIEW_WIDTH_RST;

  beat_t pending_beats[$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 0;

  function automatic beat_t status_beat(int len, int cpos, int view, bit ins, int slot);
    status_beat = '{KIND_STATUS, 8'd0, 1'b1, len[6:0], cpos[6:0], view[6:0], ins, slot[4:0]};
  endfunction

  // Apply one key event to the mirror and queue the beats it should produce.
  function automatic void edit_key(logic [3:0] cmd, logic [7:0] key);
    logic [1:0] kinds[$];
    logic [7:0] bytes[$];
    int s;
    int c;
    beat_t b;
    s = active_slot;
    if (cmd == CMD_ENTER) begin
      if (slot_len[s] != 0) begin
        for (int i = 0; i < slot_len[s]; i++) begin
          kinds.push_back(KIND_LINE);
          bytes.push_back(line_mem[s][i]);
        end
        active_slot = (s + 1) % LINES;
        slot_len[active_slot] = 0;
        slot_cur[active_slot] = 0;
        slot_view[active_slot] = 0;
      end
    end else begin
      case (cmd)
        CMD_CHAR: if (key != 0 && slot_len[s] < COLS) begin
          if (insert_mode || slot_cur[s] >= slot_len[s]) begin
            for (int i = slot_len[s]; i > slot_cur[s]; i--) line_mem[s][i] = line_mem[s][i-1];
            line_mem[s][slot_cur[s]] = key;
            slot_len[s]++;
            kinds = '{KIND_ECHO, KIND_ECHO, KIND_ECHO, KIND_ECHO, KIND_ECHO};
            bytes = '{CH_ESC, CH_LBRK, CH_ONE, CH_AT, key};
          end else begin
            line_mem[s][slot_cur[s]] = key;
            kinds.push_back(KIND_ECHO);
            bytes.push_back(key);
          end
          slot_cur[s]++;
        end
        CMD_INS:  insert_mode = ~insert_mode;
        CMD_HOME: slot_cur[s] = 0;
        CMD_END:  slot_cur[s] = slot_len[s];
        CMD_UP:
          for (int i = 0; i < LINES; i++) begin
            active_slot = (active_slot + LINES - 1) % LINES;
            if (slot_len[active_slot] != 0) break;
            if (slot_len[(active_slot + LINES - 1) % LINES] != 0) break;
          end
        CMD_DOWN:
          for (int i = 0; i < LINES; i++) begin
            active_slot = (active_slot + 1) % LINES;
            if (slot_len[active_slot] != 0) break;
            if (slot_len[(active_slot + 1) % LINES] != 0) break;
          end
        CMD_LEFT:  if (slot_cur[s] > 0) slot_cur[s]--;
        CMD_RIGHT: if (slot_cur[s] < slot_len[s]) slot_cur[s]++;
        CMD_BKSP: if (slot_len[s] > 0 && slot_cur[s] > 0) begin
          for (int i = slot_cur[s] - 1; i + 1 < slot_len[s]; i++) line_mem[s][i] = line_mem[s][i+1];
          slot_len[s]--;
          slot_cur[s]--;
          kinds = '{KIND_ECHO, KIND_ECHO, KIND_ECHO, KIND_ECHO, KIND_ECHO,
                    KIND_ECHO, KIND_ECHO, KIND_ECHO, KIND_ECHO};
          bytes = '{CH_ESC, CH_LBRK, CH_ONE, CH_D, CH_SPACE, CH_ESC, CH_LBRK, CH_ONE, CH_D};
        end
        CMD_DEL: if (slot_len[s] > 0 && slot_cur[s] < slot_len[s]) begin
          for (int i = slot_cur[s]; i + 1 < slot_len[s]; i++) line_mem[s][i] = line_mem[s][i+1];
          slot_len[s]--;
        end
        default: ;
      endcase
      // view follows the cursor of the slot the event started in
      if (slot_cur[s] < slot_view[s]) slot_view[s] = slot_cur[s];
      else if (slot_cur[s] > slot_view[s] + view_width) slot_view[s] = slot_cur[s] - view_width;
    end
    if (kinds.size() == 0) begin
      kinds.push_back(KIND_STATUS);
      bytes.push_back(8'd0);
    end
    c = active_slot;
    foreach (kinds[k]) begin
      b = status_beat(slot_len[c], slot_cur[c], slot_view[c], insert_mode, c);
      b.kind = kinds[k];
      b.data = bytes[k];
      b.last = (k == kinds.size() - 1);
      pending_beats.push_back(b);
    end
  endfunction

  task automatic send_key(logic [3:0] cmd, logic [7:0] key, bit typed = 0,
                          beat_t want = '0);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid = 0;
      @(negedge clk);
    end
    s_axis_tvalid = 1;
    s_axis_tuser = cmd;
    s_axis_tdata = key;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    edit_key(cmd, key);
    if (typed) begin
      void'(pending_beats.pop_back());
      pending_beats.push_back(want);
    end
    @(negedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid = 0;
    while (pending_beats.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_view_width(logic [7:0] w);
    drain();
    cfg_valid = 1;
    cfg_data = w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    view_width = w;
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic random_key();
    int r;
    logic [3:0] cmd;
    logic [7:0] key;
    r = $urandom_range(0, 99);
    key = ($urandom_range(0, 19) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
    if (r < 45) cmd = CMD_CHAR;
    else if (r < 50) cmd = CMD_INS;
    else if (r < 54) cmd = CMD_HOME;
    else if (r < 58) cmd = CMD_END;
    else if (r < 63) cmd = CMD_UP;
    else if (r < 68) cmd = CMD_DOWN;
    else if (r < 74) cmd = CMD_LEFT;
    else if (r < 80) cmd = CMD_RIGHT;
    else if (r < 87) cmd = CMD_BKSP;
    else if (r < 92) cmd = CMD_DEL;
    else if (r < 97) cmd = CMD_ENTER;
    else cmd = 4'($urandom_range(CMD_BAD_LO, CMD_BAD_HI));
    send_key(cmd, key);
  endtask

  // result side
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 0;
        m_axis_tready = 0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      m_axis_tready = !rst && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    beat_t got;
    beat_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tuser, m_axis_tdata[7:0], m_axis_tlast, m_axis_tdata[14:8],
              m_axis_tdata[21:15], m_axis_tdata[28:22], m_axis_tdata[29], m_axis_tdata[34:30]};
      if (pending_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %p", got);
      end else begin
        want = pending_beats.pop_front();
        if (got !== want || m_axis_tdata[39:35] !== 5'd0) begin
          mismatches++;
          if (mismatches <= 10) $display("beat mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[line_editor_with_history_top] ERROR");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  key_row_t steps[$];
  logic [7:0] widths[4] = '{8'd0, 8'd255, 8'd5, 8'd1};
  int idle_modes[4][2] = '{'{0, 0}, '{57, 0}, '{0, 57}, '{7, 7}};

  initial begin
    beat_t blank;
    foreach (slot_len[i]) begin
      slot_len[i] = 0;
      slot_cur[i] = 0;
      slot_view[i] = 0;
    end
    blank = status_beat(0, 0, 0, 1, 0);
    steps = '{
      '{CMD_BAD_LO, 8'h00, 1, blank},
      '{CMD_BAD_HI, 8'hFF, 1, blank},
      '{CMD_ENTER, 8'h00, 1, blank},
      '{CMD_BKSP, 8'h00, 1, blank},
      '{CMD_LEFT, 8'h00, 1, blank},
      '{CMD_RIGHT, 8'h00, 1, blank},
      '{CMD_UP, 8'h00, 1, blank},
      '{CMD_DOWN, 8'h00, 1, blank},
      '{CMD_CHAR, 8'h00, 1, blank},
      '{CMD_INS, 8'h00, 1, status_beat(0, 0, 0, 0, 0)},
      '{CMD_CHAR, 8'h41, 0, blank},
      '{CMD_CHAR, 8'hFF, 0, blank},
      '{CMD_CHAR, 8'h01, 0, blank},
      '{CMD_INS, 8'h00, 0, blank},
      '{CMD_HOME, 8'h00, 0, blank},
      '{CMD_CHAR, 8'h80, 0, blank},
      '{CMD_RIGHT, 8'h00, 0, blank},
      '{CMD_INS, 8'h00, 0, blank},
      '{CMD_CHAR, 8'h7F, 0, blank},
      '{CMD_INS, 8'h00, 0, blank},
      '{CMD_END, 8'h00, 0, blank},
      '{CMD_DEL, 8'h00, 0, blank},
      '{CMD_LEFT, 8'h00, 0, blank},
      '{CMD_DEL, 8'h00, 0, blank},
      '{CMD_BKSP, 8'h00, 0, blank},
      '{CMD_ENTER, 8'h00, 0, blank},
      '{CMD_UP, 8'h00, 0, blank},
      '{CMD_DOWN, 8'h00, 0, blank}
    };
    repeat (9) @(negedge clk);
    rst = 0;
    @(negedge clk);
    foreach (steps[i]) send_key(steps[i].cmd, steps[i].key, steps[i].typed, steps[i].want);

    for (int p = 0; p < 4; p++) begin
      write_view_width(widths[p]);
      send_idle_pct = idle_modes[p][0];
      recv_stall_pct = idle_modes[p][1];
      if (p == 0) hold_req = 1;
      if (p == 1) begin
        // fill the current line past its capacity from its end, then commit it
        send_key(CMD_END, 8'h00);
        for (int i = 0; i < COLS + 3; i++) send_key(CMD_CHAR, 8'($urandom_range(1, 255)));
        send_key(CMD_INS, 8'h00);
        send_key(CMD_CHAR, 8'h5A);
        send_key(CMD_INS, 8'h00);
        send_key(CMD_ENTER, 8'h00);
      end
      for (int i = 0; i < 15; i++) random_key();
    end
    write_view_width(VIEW_WIDTH_RST);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < 5; i++) random_key();

    drain();
    repeat (50) @(posedge clk);
    if (mismatches == 0 && pending_beats.size() == 0)
      $display("[line_editor_with_history_top] OK");
    else
      $display("[line_editor_with_history_top] ERROR");
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+src
src/lewh_pkg.sv
src/line_editor_with_history_top.sv
src/lewh_checker.sv
sim/line_editor_with_history_top_test.sv
